@@ hw/rtl/lswc_pkg.sv @@
// lswc_pkg: types and constants shared by the window clip pipeline
// depends on nothing
package lswc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MIN_Y = 2'd1;
	localparam logic [1:0] REG_MAX_X = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;

	// flags carried beside a point through the clip stages
	typedef struct packed {
		logic zero;
		logic sat;
	} lswc_flags_t;

endpackage

@@ hw/rtl/lswc_shift.sv @@
// lswc_shift: pipelined other + (lim - coord) * d / div with saturation
// depends on nothing; restoring divider, one quotient bit per stage
module lswc_shift #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic                in_act,
	input  logic signed [W-1:0] other,
	input  logic signed [W-1:0] lim,
	input  logic signed [W-1:0] coord,
	input  logic        [W:0]   d_mag,
	input  logic                d_neg,
	input  logic        [W:0]   div_mag,
	input  logic                div_neg,
	input  logic        [W+1:0] pass_in,
	output logic                out_valid,
	output logic signed [W-1:0] result,
	output logic                sat,
	output logic                zero,
	output logic        [W+1:0] pass_out
);
	localparam int PW = 2 * W + 2;
	localparam int ST = PW + 2;

	// stage arrays: product/remainder and quotient carried per step
	logic                      v_s   [ST+1];
	logic                      act_s [ST+1];
	logic                      neg_s [ST+1];
	logic                      z_s   [ST+1];
	logic signed [W-1:0]       oth_s [ST+1];
	logic [W:0]                div_s [ST+1];
	logic [PW-1:0]             num_s [ST+1];
	logic [W+1:0]              rem_s [ST+1];
	logic [W+1:0]              ps_s  [ST+1];

	logic signed [W:0] ld;
	logic        [W:0] nmag;
	assign ld   = $signed({lim[W-1], lim}) - $signed({coord[W-1], coord});
	assign nmag = ld[W] ? (W+1)'(-ld) : ld;

	// stage 0: difference and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			act_s[0] <= in_act && (div_mag != '0);
			z_s[0]   <= in_act && (div_mag == '0);
			neg_s[0] <= ld[W] ^ d_neg ^ div_neg;
			oth_s[0] <= other;
			div_s[0] <= div_mag;
			num_s[0] <= {{(PW-W-1){1'b0}}, nmag};
			rem_s[0] <= {1'b0, d_mag};
			ps_s[0]  <= pass_in;
		end
	end

	// stage 1: multiply, registered before the divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[1] <= 1'b0;
		end else if (en) begin
			v_s[1] <= v_s[0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			act_s[1] <= act_s[0];
			z_s[1]   <= z_s[0];
			neg_s[1] <= neg_s[0];
			oth_s[1] <= oth_s[0];
			div_s[1] <= div_s[0];
			num_s[1] <= PW'(num_s[0][W:0] * rem_s[0][W:0]);
			rem_s[1] <= '0;
			ps_s[1]  <= ps_s[0];
		end
	end

	// divider stages: num_s shifts out dividend bits, shifts in quotient bits
	for (genvar k = 2; k < PW + 2; k++) begin : g_div
		logic [W+1:0] r;
		logic         ge;
		assign r  = {rem_s[k-1][W:0], num_s[k-1][PW-1]};
		assign ge = r >= {1'b0, div_s[k-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				act_s[k] <= act_s[k-1];
				z_s[k]   <= z_s[k-1];
				neg_s[k] <= neg_s[k-1];
				oth_s[k] <= oth_s[k-1];
				div_s[k] <= div_s[k-1];
				rem_s[k] <= ge ? r - {1'b0, div_s[k-1]} : r;
				num_s[k] <= {num_s[k-1][PW-2:0], ge};
				ps_s[k]  <= ps_s[k-1];
			end
		end
	end

	// final stage: add with saturation, the quotient stays below 2^64
	logic signed [W-1:0] maxv, minv;
	logic signed [PW:0]  sum;
	assign maxv = {1'b0, {(W-1){1'b1}}};
	assign minv = {1'b1, {(W-1){1'b0}}};
	assign sum  = neg_s[ST-1]
		? $signed({{(PW-W+1){oth_s[ST-1][W-1]}}, oth_s[ST-1]}) - $signed({1'b0, num_s[ST-1]})
		: $signed({{(PW-W+1){oth_s[ST-1][W-1]}}, oth_s[ST-1]}) + $signed({1'b0, num_s[ST-1]});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[ST] <= 1'b0;
		end else if (en) begin
			v_s[ST] <= v_s[ST-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			act_s[ST] <= 1'b0;
			neg_s[ST] <= 1'b0;
			div_s[ST] <= '0;
			num_s[ST] <= '0;
			rem_s[ST] <= '0;
			z_s[ST]   <= z_s[ST-1];
			ps_s[ST]  <= ps_s[ST-1];
			if (!act_s[ST-1]) begin
				oth_s[ST] <= oth_s[ST-1];
				sat       <= 1'b0;
			end else if (sum > $signed({{(PW-W+1){1'b0}}, maxv})) begin
				oth_s[ST] <= maxv;
				sat       <= 1'b1;
			end else if (sum < $signed({{(PW-W+1){1'b1}}, minv})) begin
				oth_s[ST] <= minv;
				sat       <= 1'b1;
			end else begin
				oth_s[ST] <= sum[W-1:0];
				sat       <= 1'b0;
			end
		end
	end
	assign out_valid = v_s[ST] && act_s[ST] == 1'b0;
	assign result    = oth_s[ST];
	assign zero      = z_s[ST];
	assign pass_out  = ps_s[ST];
endmodule

@@ hw/rtl/line_segment_window_clip.sv @@
// line_segment_window_clip: clips both endpoints of a segment to a window
// pipeline: input register, four shift pipelines in a row, output register
// throughput: one segment per cycle, stalls freeze the whole pipeline
// reset (arst_n low) clears the window registers and all valid bits
// depends on lswc_pkg and lswc_shift
module line_segment_window_clip #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [4*COORD_WIDTH-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero, sat, pad
	output logic [4*COORD_WIDTH+7:0] m_tdata,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data
);
	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] mnx_q, mny_q, mxx_q, mxy_q;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mnx_q <= '0; mny_q <= '0; mxx_q <= '0; mxy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lswc_pkg::REG_MIN_X: mnx_q <= cfg_data;
				lswc_pkg::REG_MIN_Y: mny_q <= cfg_data;
				lswc_pkg::REG_MAX_X: mxx_q <= cfg_data;
				lswc_pkg::REG_MAX_Y: mxy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register stalls the pipeline when full and not taken
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// segment deltas, kept as sign and magnitude
	logic signed [W-1:0] sx, sy, ex, ey;
	logic signed [W:0]   dxs, dys;
	assign sx  = s_tdata[W-1:0];
	assign sy  = s_tdata[2*W-1:W];
	assign ex  = s_tdata[3*W-1:2*W];
	assign ey  = s_tdata[4*W-1:3*W];
	assign dxs = $signed({ex[W-1], ex}) - $signed({sx[W-1], sx});
	assign dys = $signed({ey[W-1], ey}) - $signed({sy[W-1], sy});

	// register the input transfer
	logic          v_s1;
	logic [W-1:0]  sx_s1, sy_s1, ex_s1, ey_s1;
	logic [W:0]    dxm_s1, dym_s1;
	logic          dxn_s1, dyn_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= sx; sy_s1 <= sy; ex_s1 <= ex; ey_s1 <= ey;
			dxn_s1 <= dxs[W]; dyn_s1 <= dys[W];
			dxm_s1 <= dxs[W] ? (W+1)'(-dxs) : dxs;
			dym_s1 <= dys[W] ? (W+1)'(-dys) : dys;
		end
	end

	// four phases: start x, start y, end x, end y; a side queue carries the rest
	localparam int LAT = 2 * W + 5;
	localparam int SW  = 4 * W + 6;
	logic [SW-1:0] side [4][LAT];
	logic [SW-1:0] side_in [4];
	logic          pv [5];
	logic [W-1:0]  px [5], py [5];
	logic          pz [5], ps [5];
	logic [W:0]    pdxm [5], pdym [5];
	logic          pdxn [5], pdyn [5];
	logic [W-1:0]  ox [5], oy [5];

	assign pv[0] = v_s1; assign px[0] = sx_s1; assign py[0] = sy_s1;
	assign ox[0] = ex_s1; assign oy[0] = ey_s1;
	assign pz[0] = 1'b0; assign ps[0] = 1'b0;
	assign pdxm[0] = dxm_s1; assign pdym[0] = dym_s1;
	assign pdxn[0] = dxn_s1; assign pdyn[0] = dyn_s1;

	for (genvar p = 0; p < 4; p++) begin : g_ph
		localparam bit ISX = (p % 2) == 0;
		logic signed [W-1:0] c, o, mn, mx, lim, res;
		logic                hit, vo, so, zo;
		logic [W:0]          dm, vm;
		logic                dn, vn;
		logic [W+1:0]        pin, pout;
		logic [SW-1:0]       sd;
		assign c   = ISX ? px[p] : py[p];
		assign o   = ISX ? py[p] : px[p];
		assign mn  = ISX ? mnx_q : mny_q;
		assign mx  = ISX ? mxx_q : mxy_q;
		assign hit = (c < mn) || (c > mx);
		assign lim = (c < mn) ? mn : mx;
		assign dm  = ISX ? pdym[p] : pdxm[p];
		assign dn  = ISX ? pdyn[p] : pdxn[p];
		assign vm  = ISX ? pdxm[p] : pdym[p];
		assign vn  = ISX ? pdxn[p] : pdyn[p];
		assign pin = {pz[p], ps[p], W'(hit ? lim : c)};
		lswc_shift #(.W(W)) u_sh (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pv[p]), .in_act(hit),
			.other(o), .lim(lim), .coord(c), .d_mag(dm), .d_neg(dn),
			.div_mag(vm), .div_neg(vn), .pass_in(pin),
			.out_valid(vo), .result(res), .sat(so), .zero(zo), .pass_out(pout)
		);
		assign side_in[p] = {ox[p], oy[p], pdxm[p], pdym[p], pdxn[p], pdyn[p], 2'b00};
		always_ff @(posedge clk) begin
			if (en) begin
				side[p][0] <= side_in[p];
				for (int k = 1; k < LAT; k++) side[p][k] <= side[p][k-1];
			end
		end
		assign sd = side[p][LAT-1];
		assign pv[p+1]   = vo;
		assign pz[p+1]   = pout[W+1] | zo;
		assign ps[p+1]   = pout[W] | so;
		assign pdxm[p+1] = sd[2*W+5:W+5];
		assign pdym[p+1] = sd[W+4:4];
		assign pdxn[p+1] = sd[3];
		assign pdyn[p+1] = sd[2];
		if (p == 1) begin : g_sw
			// after the start point, swap in the end point
			assign px[p+1] = sd[SW-1:SW-W];
			assign py[p+1] = sd[SW-W-1:SW-2*W];
			assign ox[p+1] = res;
			assign oy[p+1] = pout[W-1:0];
		end else begin : g_nsw
			assign px[p+1] = ISX ? pout[W-1:0] : res;
			assign py[p+1] = ISX ? res : pout[W-1:0];
			assign ox[p+1] = sd[SW-1:SW-W];
			assign oy[p+1] = sd[SW-W-1:SW-2*W];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= pv[4];
	end
	always_ff @(posedge clk) begin
		if (en) m_tdata <= {6'b0, ps[4], pz[4], py[4], px[4], oy[4], ox[4]};
	end

	// a stalled output holds, ready follows the output register, the input stage valid freezes in a stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1)) else $error("stage moved in stall");
endmodule

@@ dv/testbench.sv @@
// testbench for line_segment_window_clip: random and directed segments,
// checked against an in-bench clip predictor across several windows
// depends on lswc_pkg and the line_segment_window_clip rtl
`timescale 1ns / 1ps

module testbench;

	localparam int W = 32;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam int LATENCY = 4 * (2 * W + 5) + 2;

	typedef struct {
		logic [W-1:0] sx, sy, ex, ey;
		logic         zero, sat;
	} clip_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// start_x, start_y, end_x, end_y
	logic [4*W-1:0]    s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero, sat, pad
	logic [4*W+7:0]    m_tdata;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = lswc_pkg::REG_MIN_X;
	logic [W-1:0]      cfg_data = '0;

	logic [4*W-1:0]    segment_queue[$];
	clip_result_t      clipped_queue[$];
	longint            window[4];
	bit                taken = 1'b0;
	bit                quiet = 1'b0;
	bit                failed = 1'b0;
	int                send_gap = 0;
	int                stall_gap = 0;

	line_segment_window_clip #(.COORD_WIDTH(W)) dut (.*);

	always #4 clk = ~clk;

	// other + num * d / dv truncated toward zero, saturated
	task automatic shift_along(inout longint other, input longint num, input longint d,
			input longint dv, inout bit sat);
		bit           neg;
		logic [127:0] prod;
		logic [127:0] q;
		longint       room;
		neg = (num < 0) ^ (d < 0) ^ (dv < 0);
		prod = 128'(num < 0 ? -num : num) * 128'(d < 0 ? -d : d);
		q = prod / 128'(dv < 0 ? -dv : dv);
		if (q != 0) begin
			room = neg ? other - COORD_MIN : COORD_MAX - other;
			if (q > 128'(room)) begin
				sat = 1'b1;
				other = neg ? COORD_MIN : COORD_MAX;
			end else begin
				other = neg ? other - longint'(q) : other + longint'(q);
			end
		end
	endtask

	// x against the window first, then the updated y
	task automatic clip_point(inout longint x, inout longint y, input longint dx,
			input longint dy, inout bit zero, inout bit sat);
		longint edge_val;
		bit     hit;
		hit = 1'b1;
		if (x < window[lswc_pkg::REG_MIN_X]) edge_val = window[lswc_pkg::REG_MIN_X];
		else if (x > window[lswc_pkg::REG_MAX_X]) edge_val = window[lswc_pkg::REG_MAX_X];
		else hit = 1'b0;
		if (hit) begin
			if (dx == 0) zero = 1'b1;
			else shift_along(y, edge_val - x, dy, dx, sat);
			x = edge_val;
		end
		hit = 1'b1;
		if (y < window[lswc_pkg::REG_MIN_Y]) edge_val = window[lswc_pkg::REG_MIN_Y];
		else if (y > window[lswc_pkg::REG_MAX_Y]) edge_val = window[lswc_pkg::REG_MAX_Y];
		else hit = 1'b0;
		if (hit) begin
			if (dy == 0) zero = 1'b1;
			else shift_along(x, edge_val - y, dx, dy, sat);
			y = edge_val;
		end
	endtask

	task automatic predict_clip(input logic [4*W-1:0] seg, output clip_result_t r);
		longint x1, y1, x2, y2, dx, dy;
		bit     zero, sat;
		x1 = longint'($signed(seg[W-1:0]));
		y1 = longint'($signed(seg[2*W-1:W]));
		x2 = longint'($signed(seg[3*W-1:2*W]));
		y2 = longint'($signed(seg[4*W-1:3*W]));
		dx = x2 - x1;
		dy = y2 - y1;
		zero = 1'b0;
		sat = 1'b0;
		clip_point(x1, y1, dx, dy, zero, sat);
		clip_point(x2, y2, dx, dy, zero, sat);
		r.sx = x1[W-1:0];
		r.sy = y1[W-1:0];
		r.ex = x2[W-1:0];
		r.ey = y2[W-1:0];
		r.zero = zero;
		r.sat = sat;
	endtask

	// segment driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (segment_queue.size() > 0) begin
				s_tdata <= segment_queue.pop_front();
				s_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (stall_gap > 0) begin
			m_tready <= 1'b0;
			stall_gap <= stall_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0) stall_gap <= $urandom_range(1, 7);
		end
	end

	// input transfer: predict
	always @(posedge clk) begin
		clip_result_t r;
		taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			predict_clip(s_tdata, r);
			clipped_queue.insert(clipped_queue.size(), r);
		end
	end

	// output transfer: compare with the oldest expectation
	always @(posedge clk) begin
		clip_result_t r;
		if (m_tvalid && m_tready) begin
			if (clipped_queue.size() == 0) begin
				$error("result with no segment outstanding");
				failed = 1'b1;
			end else begin
				r = clipped_queue.pop_front();
				if (m_tdata[W-1:0] !== r.sx) begin
					$error("clipped_start_x expected %h actual %h", r.sx, m_tdata[W-1:0]);
					failed = 1'b1;
				end
				if (m_tdata[2*W-1:W] !== r.sy) begin
					$error("clipped_start_y expected %h actual %h", r.sy, m_tdata[2*W-1:W]);
					failed = 1'b1;
				end
				if (m_tdata[3*W-1:2*W] !== r.ex) begin
					$error("clipped_end_x expected %h actual %h", r.ex, m_tdata[3*W-1:2*W]);
					failed = 1'b1;
				end
				if (m_tdata[4*W-1:3*W] !== r.ey) begin
					$error("clipped_end_y expected %h actual %h", r.ey, m_tdata[4*W-1:3*W]);
					failed = 1'b1;
				end
				if (m_tdata[4*W] !== r.zero) begin
					$error("zero_slope_flag expected %b actual %b", r.zero, m_tdata[4*W]);
					failed = 1'b1;
				end
				if (m_tdata[4*W+1] !== r.sat) begin
					$error("saturated_flag expected %b actual %b", r.sat, m_tdata[4*W+1]);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic logic [W-1:0] fix(int v);
		return W'(v <<< 16);
	endfunction

	function automatic logic [4*W-1:0] seg_of(logic [W-1:0] x1, logic [W-1:0] y1,
			logic [W-1:0] x2, logic [W-1:0] y2);
		return {y2, x2, y1, x1};
	endfunction

	// append one segment to the pending queue
	task automatic add_segment(logic [W-1:0] x1, logic [W-1:0] y1, logic [W-1:0] x2,
			logic [W-1:0] y2);
		segment_queue.insert(segment_queue.size(), seg_of(x1, y1, x2, y2));
	endtask

	// coordinate mostly near the window, sometimes wild or extreme
	function automatic logic [W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			3: return fix(int'($urandom_range(0, 40)) - 20);
			default: return W'(longint'(window[$urandom_range(0, 3)])
				+ longint'(int'($urandom_range(0, 32'h00300000)) - 32'sh00180000));
		endcase
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		window[idx] = longint'($signed(val));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(logic [W-1:0] x0, logic [W-1:0] y0, logic [W-1:0] x1,
			logic [W-1:0] y1);
		write_reg(lswc_pkg::REG_MIN_X, x0);
		write_reg(lswc_pkg::REG_MIN_Y, y0);
		write_reg(lswc_pkg::REG_MAX_X, x1);
		write_reg(lswc_pkg::REG_MAX_Y, y1);
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (segment_queue.size() > 0 || (s_tvalid && !taken) || clipped_queue.size() > 0);
	endtask

	task automatic random_segments(int n);
		repeat (n) add_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		drain();
	endtask

	initial begin
		window = '{default: 0};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window: a single point at the origin
		random_segments(40);

		// directed segments against a 20 x 20 window
		set_window(fix(-10), fix(-10), fix(10), fix(10));
		add_segment(fix(1), fix(2), fix(3), fix(-4));
		add_segment(fix(-20), fix(0), fix(20), fix(5));
		add_segment(fix(0), fix(-30), fix(3), fix(30));
		add_segment(fix(-30), fix(-30), fix(30), fix(30));
		add_segment(fix(-30), fix(20), fix(5), fix(-25));
		// vertical and horizontal lines outside the window
		add_segment(fix(15), fix(-3), fix(15), fix(4));
		add_segment(fix(-4), fix(12), fix(4), fix(12));
		add_segment(fix(-12), fix(-12), fix(-12), fix(-12));
		// field extremes and saturating shifts
		add_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		add_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		add_segment(32'h80000000, 32'h7fffffff, 32'h80000001, 32'h80000000);
		add_segment(32'h7fffffff, 32'h00000000, 32'h7ffffffe, 32'h80000000);
		add_segment(32'hffffffff, 32'h00000001, 32'h00000000, 32'h00000000);
		add_segment(fix(-11), fix(11), fix(11), fix(-11));
		add_segment(fix(10), fix(10), fix(-10), fix(-10));
		drain();
		random_segments(200);

		// inverted window
		set_window(fix(5), fix(8), fix(-5), fix(-8));
		random_segments(150);

		// widest window: nothing is clipped
		set_window(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		random_segments(100);

		// window pinned at the positive corner
		set_window(32'h7ffffff0, 32'h7fff0000, 32'h7fffffff, 32'h7fffffff);
		random_segments(150);

		// window pinned at the negative corner
		set_window(32'h80000000, 32'h80000000, 32'h80010000, 32'h80000010);
		random_segments(150);

		// random window, then a final stretch with no idling
		set_window($urandom() | 32'h80000000, $urandom() | 32'h80000000,
			$urandom() & 32'h7fffffff, $urandom() & 32'h7fffffff);
		random_segments(150);
		quiet = 1'b1;
		random_segments(100);

		repeat (LATENCY + 20) @(posedge clk);
		if (!failed && clipped_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lswc_pkg.sv
hw/rtl/lswc_shift.sv
hw/rtl/line_segment_window_clip.sv
dv/testbench.sv
